>>> hdl/segmented_prime_sieve_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segmented prime sieve unit
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_PRIME_SIEVE_UNIT_ASSERT_SVH
`define SEGMENTED_PRIME_SIEVE_UNIT_ASSERT_SVH

// same-cycle implication
`define SPSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spsu: implication check failed");

// next-cycle implication
`define SPSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spsu: next-cycle check failed");

`endif

>>> hdl/spsu_pkg.sv
// ----------------------------------------------------------------------------
// spsu_pkg
// Shared constants and types of the segmented prime sieve unit.
// ----------------------------------------------------------------------------
package spsu_pkg;

    localparam int unsigned BLOCK_WORDS_DEF = 64;
    localparam int unsigned SMALL_LIMIT_DEF = 65536;
    localparam int unsigned PRIME_SLOTS_DEF = 6542;

    localparam int unsigned BLK_W   = 18;  // block index
    localparam int unsigned LIMIT_W = 31;  // upper limit register
    localparam int unsigned WIDX_W  = 6;   // word index in a block
    localparam int unsigned WORD_W  = 64;  // bitmap word
    localparam int unsigned PRIME_W = 16;  // sieving prime
    localparam int unsigned CNT_W   = 13;  // prime table count
    localparam int unsigned NUM_W   = 32;  // block base / end numbers
    localparam int unsigned IDX_W   = 18;  // bit index within a block

    typedef struct packed {
        logic             busy;
        logic             ready;
        logic [CNT_W-1:0] total;
    } tbl_stat_t;

endpackage

>>> hdl/spsu_ifs.sv
// ----------------------------------------------------------------------------
// spsu channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface spsu_in_if;
    import spsu_pkg::*;
    logic             valid;
    logic             ready;
    logic [BLK_W-1:0] block_index;
    modport source (output valid, output block_index, input ready);
    modport sink   (input valid, input block_index, output ready);
endinterface

interface spsu_out_if;
    import spsu_pkg::*;
    logic              valid;
    logic              ready;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] prime_mask;
    logic              includes_two;
    logic              last;
    modport source (output valid, output word_index, output prime_mask,
                    output includes_two, output last, input ready);
    modport sink   (input valid, input word_index, input prime_mask,
                    input includes_two, input last, output ready);
endinterface

interface spsu_cfg_if;
    import spsu_pkg::*;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] upper_limit;
    modport source (output valid, output upper_limit, input ready);
    modport sink   (input valid, input upper_limit, output ready);
endinterface

>>> hdl/spsu_mod.sv
// ----------------------------------------------------------------------------
// spsu_mod
// Bit-serial restoring remainder unit: block base modulo a sieving prime.
// ----------------------------------------------------------------------------
module spsu_mod
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [spsu_pkg::NUM_W-1:0]    dividend,
    input  logic [spsu_pkg::PRIME_W-1:0]  divisor,
    output logic                          busy,
    output logic                          done,
    output logic [spsu_pkg::PRIME_W-1:0]  rem
);
    import spsu_pkg::*;

    localparam int unsigned STEP_W = $clog2(NUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [PRIME_W-1:0] rem_reg, rem_next;
    logic [PRIME_W-1:0] dsr_reg, dsr_next;
    logic [PRIME_W:0]  trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
                rem_next = PRIME_W'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[PRIME_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

>>> hdl/spsu_table.sv
// ----------------------------------------------------------------------------
// spsu_table
// Builds the sieving prime table once: clears the small odd map, crosses off
// composites, then collects the surviving primes into the prime memory.
// ----------------------------------------------------------------------------
module spsu_table #(
    parameter int unsigned SMALL_LIMIT = spsu_pkg::SMALL_LIMIT_DEF,
    parameter int unsigned PRIME_SLOTS = spsu_pkg::PRIME_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output spsu_pkg::tbl_stat_t           stat,
    input  logic [spsu_pkg::CNT_W-1:0]    rd_addr,
    output logic [spsu_pkg::PRIME_W-1:0]  rd_data
);
    import spsu_pkg::*;

    localparam int unsigned HALF = SMALL_LIMIT / 2;
    localparam int unsigned K_W  = $clog2(HALF);
    localparam int unsigned P_W  = K_W + 1;
    localparam int unsigned M_W  = K_W + 2;
    localparam int unsigned SQ_W = 2 * P_W;
    localparam int unsigned PA_W = $clog2(PRIME_SLOTS);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_CLR  = 3'd1;
    localparam logic [2:0] T_MRD  = 3'd2;
    localparam logic [2:0] T_MCHK = 3'd3;
    localparam logic [2:0] T_MARK = 3'd4;
    localparam logic [2:0] T_CPUT = 3'd5;
    localparam logic [2:0] T_CRD  = 3'd6;
    localparam logic [2:0] T_CCHK = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [M_W-1:0]   m_reg, m_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ready_reg, ready_next;
    logic [P_W-1:0]   p;

    // odd-number map: entry k stands for 2k+1, set means composite
    logic             map_mem [HALF];
    logic             map_we;
    logic [K_W-1:0]   map_waddr;
    logic             map_wdata;
    logic             map_q;

    logic [PRIME_W-1:0] prime_mem [PRIME_SLOTS];
    logic               pr_we;
    logic [PA_W-1:0]    pr_waddr;
    logic [PRIME_W-1:0] pr_wdata;
    logic [PRIME_W-1:0] rd_data_reg;

    assign p = {k_reg, 1'b1};

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        sq_next    = sq_reg;
        cnt_next   = cnt_reg;
        ready_next = ready_reg;
        map_we     = 1'b0;
        map_waddr  = k_reg;
        map_wdata  = 1'b0;
        pr_we      = 1'b0;
        pr_waddr   = cnt_reg[PA_W-1:0];
        pr_wdata   = PRIME_W'(p);
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    k_next     = '0;
                    cnt_next   = '0;
                    state_next = T_CLR;
                end
            end
            T_CLR:
            begin
                map_we = 1'b1;
                k_next = k_reg + 1'b1;
                if (k_reg == K_W'(HALF - 1))
                begin
                    k_next     = K_W'(1);
                    state_next = T_MRD;
                end
            end
            T_MRD:
            begin
                sq_next    = SQ_W'(p) * SQ_W'(p);
                state_next = T_MCHK;
            end
            T_MCHK:
            begin
                if (sq_reg >= SQ_W'(SMALL_LIMIT))
                    state_next = T_CPUT;
                else if (map_q)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = T_MRD;
                end
                else
                begin
                    m_next     = M_W'(sq_reg[K_W:1]);
                    state_next = T_MARK;
                end
            end
            T_MARK:
            begin
                map_we    = 1'b1;
                map_waddr = m_reg[K_W-1:0];
                map_wdata = 1'b1;
                m_next    = m_reg + M_W'(p);
                if (m_reg + M_W'(p) >= M_W'(HALF))
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = T_MRD;
                end
            end
            T_CPUT:
            begin
                pr_we      = 1'b1;
                pr_waddr   = '0;
                pr_wdata   = PRIME_W'(2);
                cnt_next   = CNT_W'(1);
                k_next     = K_W'(1);
                state_next = T_CRD;
            end
            T_CRD:
            begin
                state_next = T_CCHK;
            end
            T_CCHK:
            begin
                if (!map_q && cnt_reg < CNT_W'(PRIME_SLOTS))
                begin
                    pr_we    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (k_reg == K_W'(HALF - 1))
                begin
                    ready_next = 1'b1;
                    state_next = T_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = T_CRD;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            cnt_reg   <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ready_reg <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg  <= k_next;
        m_reg  <= m_next;
        sq_reg <= sq_next;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        map_q <= map_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pr_we)
            prime_mem[pr_waddr] <= pr_wdata;
        rd_data_reg <= prime_mem[rd_addr[PA_W-1:0]];
    end

    assign rd_data     = rd_data_reg;
    assign stat.busy   = (state_reg != T_IDLE);
    assign stat.ready  = ready_reg;
    assign stat.total  = cnt_reg;

endmodule

>>> hdl/spsu_block.sv
// ----------------------------------------------------------------------------
// spsu_block
// Sieves one block in the bitmap memory (read-modify-write per mark) and
// streams the masked prime words through the output register.
// ----------------------------------------------------------------------------
`include "segmented_prime_sieve_unit_assert.svh"

module spsu_block #(
    parameter int unsigned BLOCK_WORDS = spsu_pkg::BLOCK_WORDS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    spsu_in_if.sink                       req,
    spsu_out_if.source                    rsp,
    input  logic [spsu_pkg::LIMIT_W-1:0]  limit,
    output logic                          tbl_start,
    input  spsu_pkg::tbl_stat_t           tbl_stat,
    output logic [spsu_pkg::CNT_W-1:0]    prime_raddr,
    input  logic [spsu_pkg::PRIME_W-1:0]  prime_rdata
);
    import spsu_pkg::*;

    localparam int unsigned BLOCK_SPAN = 128 * BLOCK_WORDS;
    localparam int unsigned BLOCK_BITS = 64 * BLOCK_WORDS;
    localparam int unsigned WA_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BUILD = 4'd1;
    localparam logic [3:0] S_BASE  = 4'd2;
    localparam logic [3:0] S_CLR   = 4'd3;
    localparam logic [3:0] S_PRD   = 4'd4;
    localparam logic [3:0] S_PWAIT = 4'd5;
    localparam logic [3:0] S_PSQ   = 4'd6;
    localparam logic [3:0] S_PCMP  = 4'd7;
    localparam logic [3:0] S_MODW  = 4'd8;
    localparam logic [3:0] S_MRD   = 4'd9;
    localparam logic [3:0] S_MWR   = 4'd10;
    localparam logic [3:0] S_ERD   = 4'd11;
    localparam logic [3:0] S_EWAIT = 4'd12;

    logic [3:0]         state_reg, state_next;
    logic [BLK_W-1:0]   blk_reg, blk_next;
    logic [NUM_W-1:0]   base_reg, base_next;
    logic [NUM_W-1:0]   end_reg, end_next;
    logic [NUM_W-1:0]   first_reg, first_next;
    logic [NUM_W-1:0]   sq_reg, sq_next;
    logic [PRIME_W-1:0] p_reg, p_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [WA_W-1:0]    w_reg, w_next;
    logic               w_last;

    logic               ov_reg, ov_next;
    logic [WIDX_W-1:0]  owi_reg, owi_next;
    logic [WORD_W-1:0]  omask_reg, omask_next;
    logic               otwo_reg, otwo_next;
    logic               olast_reg, olast_next;

    logic               mod_start, mod_busy, mod_done;
    logic [PRIME_W-1:0] mod_rem;
    logic [PRIME_W:0]   x0, x1;
    logic [NUM_W-1:0]   sq_off;

    logic [WORD_W-1:0]  bm_mem [BLOCK_WORDS];
    logic               bm_we;
    logic [WA_W-1:0]    bm_waddr, bm_raddr;
    logic [WORD_W-1:0]  bm_wdata, bm_q;

    logic [NUM_W-1:0]   lim_ext, lim_gap;
    logic [5:0]         lim_cnt;
    logic [WORD_W-1:0]  lim_mask;

    spsu_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (base_reg),
        .divisor  (p_reg),
        .busy     (mod_busy),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign w_last = (w_reg == WA_W'(BLOCK_WORDS - 1));
    assign sq_off = sq_reg - base_reg;
    assign x0     = {1'b0, p_reg} - {1'b0, mod_rem};
    assign x1     = x0[0] ? x0 : (x0 + {1'b0, p_reg});

    // mask of numbers first + 2b that do not exceed the limit
    assign lim_ext = NUM_W'(limit);
    assign lim_gap = lim_ext - first_reg;
    assign lim_cnt = lim_gap[6:1] + 6'd1;
    always_comb
    begin
        if (first_reg > lim_ext)
            lim_mask = '0;
        else if (first_reg + NUM_W'(126) <= lim_ext)
            lim_mask = '1;
        else
            lim_mask = ~({WORD_W{1'b1}} << lim_cnt);
    end

    always_comb
    begin
        state_next = state_reg;
        blk_next   = blk_reg;
        base_next  = base_reg;
        end_next   = end_reg;
        first_next = first_reg;
        sq_next    = sq_reg;
        p_next     = p_reg;
        j_next     = j_reg;
        idx_next   = idx_reg;
        w_next     = w_reg;
        ov_next    = ov_reg;
        owi_next   = owi_reg;
        omask_next = omask_reg;
        otwo_next  = otwo_reg;
        olast_next = olast_reg;
        tbl_start  = 1'b0;
        mod_start  = 1'b0;
        bm_we      = 1'b0;
        bm_waddr   = w_reg;
        bm_wdata   = '0;
        bm_raddr   = w_reg;

        if (ov_reg && rsp.ready)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    blk_next = req.block_index;
                    if (!tbl_stat.ready)
                    begin
                        tbl_start  = 1'b1;
                        state_next = S_BUILD;
                    end
                    else
                        state_next = S_BASE;
                end
            end
            S_BUILD:
            begin
                if (tbl_stat.ready)
                    state_next = S_BASE;
            end
            S_BASE:
            begin
                base_next  = NUM_W'(blk_reg) * NUM_W'(BLOCK_SPAN);
                w_next     = '0;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                end_next = base_reg + NUM_W'(BLOCK_SPAN);
                bm_we    = 1'b1;
                // one is not prime
                bm_wdata = WORD_W'((w_reg == '0) && (base_reg == '0));
                w_next   = w_reg + 1'b1;
                if (w_last)
                begin
                    j_next     = CNT_W'(1);
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                if (j_reg >= tbl_stat.total)
                begin
                    w_next     = '0;
                    first_next = base_reg + NUM_W'(1);
                    state_next = S_ERD;
                end
                else
                    state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                p_next     = prime_rdata;
                state_next = S_PSQ;
            end
            S_PSQ:
            begin
                sq_next    = NUM_W'(p_reg) * NUM_W'(p_reg);
                state_next = S_PCMP;
            end
            S_PCMP:
            begin
                if (sq_reg >= end_reg)
                begin
                    w_next     = '0;
                    first_next = base_reg + NUM_W'(1);
                    state_next = S_ERD;
                end
                else if (sq_reg > base_reg)
                begin
                    idx_next   = sq_off[IDX_W:1];
                    state_next = S_MRD;
                end
                else
                begin
                    mod_start  = 1'b1;
                    state_next = S_MODW;
                end
            end
            S_MODW:
            begin
                if (mod_done)
                begin
                    idx_next   = IDX_W'(x1[PRIME_W:1]);
                    state_next = S_MRD;
                end
            end
            S_MRD:
            begin
                bm_raddr = idx_reg[6 +: WA_W];
                if (idx_reg >= IDX_W'(BLOCK_BITS))
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_PRD;
                end
                else
                    state_next = S_MWR;
            end
            S_MWR:
            begin
                bm_we      = 1'b1;
                bm_waddr   = idx_reg[6 +: WA_W];
                bm_wdata   = bm_q | (WORD_W'(1) << idx_reg[5:0]);
                idx_next   = idx_reg + IDX_W'(p_reg);
                state_next = S_MRD;
            end
            S_ERD:
            begin
                if (!ov_reg || rsp.ready)
                    state_next = S_EWAIT;
            end
            S_EWAIT:
            begin
                ov_next    = 1'b1;
                owi_next   = WIDX_W'(w_reg);
                omask_next = ~bm_q & lim_mask;
                otwo_next  = (blk_reg == '0) && (w_reg == '0) && (lim_ext >= NUM_W'(2));
                olast_next = w_last;
                w_next     = w_reg + 1'b1;
                first_next = first_reg + NUM_W'(128);
                state_next = w_last ? S_IDLE : S_ERD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg   <= blk_next;
        base_reg  <= base_next;
        end_reg   <= end_next;
        first_reg <= first_next;
        sq_reg    <= sq_next;
        p_reg     <= p_next;
        j_reg     <= j_next;
        idx_reg   <= idx_next;
        w_reg     <= w_next;
        owi_reg   <= owi_next;
        omask_reg <= omask_next;
        otwo_reg  <= otwo_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
            bm_mem[bm_waddr] <= bm_wdata;
        bm_q <= bm_mem[bm_raddr];
    end

    assign prime_raddr      = j_reg;
    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = ov_reg;
    assign rsp.word_index   = owi_reg;
    assign rsp.prime_mask   = omask_reg;
    assign rsp.includes_two = otwo_reg;
    assign rsp.last         = olast_reg;

    `SPSU_ASSERT_IMPL(a_mark_in_block, clk, rst_n, state_reg == S_MWR, idx_reg < IDX_W'(BLOCK_BITS))
    `SPSU_ASSERT_NEXT(a_last_word_idle, clk, rst_n, state_reg == S_EWAIT && w_last, state_reg == S_IDLE)
    `SPSU_ASSERT_IMPL(a_emit_after_table, clk, rst_n, ov_reg, tbl_stat.ready)
    `SPSU_ASSERT_IMPL(a_mod_start_idle, clk, rst_n, mod_start, !mod_busy)
    `SPSU_ASSERT_IMPL(a_build_busy, clk, rst_n, state_reg == S_BUILD && !tbl_stat.ready, tbl_stat.busy)

endmodule

>>> hdl/segmented_prime_sieve_unit.sv
// Operation: the first request builds the prime table; then every block
//   clears the bitmap, takes each sieving prime (with a base modulo when its
//   square is not above the block base), crosses off its multiples by bitmap
//   read-modify-write, and streams out the masked words.
// Throughput: one block at a time; a new request is taken once the last word
//   is in the output register. Reset clears control state and the table flag.
// ----------------------------------------------------------------------------
// segmented_prime_sieve_unit
// Segmented sieve of odd numbers with a built-once sieving prime table.
// ----------------------------------------------------------------------------
module segmented_prime_sieve_unit #(
    parameter int unsigned BLOCK_WORDS = spsu_pkg::BLOCK_WORDS_DEF,
    parameter int unsigned SMALL_LIMIT = spsu_pkg::SMALL_LIMIT_DEF,
    parameter int unsigned PRIME_SLOTS = spsu_pkg::PRIME_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    spsu_in_if.sink     req,
    spsu_cfg_if.sink    cfg,
    spsu_out_if.source  rsp
);
    import spsu_pkg::*;

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    tbl_stat_t          tbl_stat;
    logic               tbl_start;
    logic [CNT_W-1:0]   prime_raddr;
    logic [PRIME_W-1:0] prime_rdata;

    assign cfg.ready  = 1'b1;
    assign limit_next = (cfg.valid) ? cfg.upper_limit : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '0;
        else
            limit_reg <= limit_next;
    end

    spsu_table #(
        .SMALL_LIMIT (SMALL_LIMIT),
        .PRIME_SLOTS (PRIME_SLOTS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (tbl_start),
        .stat    (tbl_stat),
        .rd_addr (prime_raddr),
        .rd_data (prime_rdata)
    );

    spsu_block #(
        .BLOCK_WORDS (BLOCK_WORDS)
    ) u_block (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .limit       (limit_reg),
        .tbl_start   (tbl_start),
        .tbl_stat    (tbl_stat),
        .prime_raddr (prime_raddr),
        .prime_rdata (prime_rdata)
    );

endmodule
